### hdl/tsf_pkg.sv
// ----------------------------------------------------------------------------
// tsf_pkg
// Shared widths, constants and node tables for the tetrahedron shape
// function evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package tsf_pkg;

	localparam int FRAC_BITS = 16;
	localparam int IN_W      = 18;
	localparam int OUT_W     = 24;
	localparam int IDX_W     = 4;
	localparam int ORD_W     = 2;

	// barycentric coordinates: input or one, plus headroom for the sum of four
	localparam int BASE_W  = (FRAC_BITS + 1 > IN_W) ? FRAC_BITS + 1 : IN_W;
	localparam int LAM_W   = BASE_W + 2;
	localparam int MUL_A_W = LAM_W + 2;
	localparam int PROD_W  = MUL_A_W + LAM_W;
	localparam int GRAD_W  = LAM_W + 4;

	localparam logic signed [LAM_W-1:0]  ONE  = LAM_W'(2 ** FRAC_BITS);
	localparam logic signed [PROD_W:0]   HALF = (PROD_W + 1)'(2 ** (FRAC_BITS - 1));
	localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(2 ** (OUT_W - 1) - 1);
	localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

	localparam logic [ORD_W-1:0] ORDER_LINEAR = 2'd1;
	localparam logic [ORD_W-1:0] ORDER_QUAD   = 2'd2;

	localparam logic [IDX_W-1:0] LAST_LINEAR = 4'd3;
	localparam logic [IDX_W-1:0] LAST_QUAD   = 4'd9;

	typedef logic signed [LAM_W-1:0] lam_t;

	typedef struct packed {
		logic [IDX_W-1:0]        node_index;
		logic signed [OUT_W-1:0] shape_value;
		logic signed [OUT_W-1:0] grad_xi;
		logic signed [OUT_W-1:0] grad_eta;
		logic signed [OUT_W-1:0] grad_zeta;
		logic                    last_node;
	} node_res_t;

	// first barycentric coordinate of a node
	function automatic logic [1:0] node_a(input logic [IDX_W-1:0] k);
		logic [1:0] r;
		case (k)
			4'd1, 4'd4, 4'd5, 4'd9: r = 2'd1;
			4'd2, 4'd6, 4'd8:       r = 2'd2;
			4'd3, 4'd7:             r = 2'd3;
			default:                r = 2'd0;
		endcase
		return r;
	endfunction

	// second barycentric coordinate of a node (same as the first on corners)
	function automatic logic [1:0] node_b(input logic [IDX_W-1:0] k);
		logic [1:0] r;
		case (k)
			4'd1:             r = 2'd1;
			4'd2, 4'd5:       r = 2'd2;
			4'd3, 4'd8, 4'd9: r = 2'd3;
			default:          r = 2'd0;
		endcase
		return r;
	endfunction

	// derivative sign of barycentric coordinate l by reference direction d
	function automatic logic signed [1:0] lam_grad(input logic [1:0] l, input int d);
		logic signed [1:0] r;
		if (l == 2'd0)
			r = -2'sd1;
		else if (int'(l) == d + 1)
			r = 2'sd1;
		else
			r = 2'sd0;
		return r;
	endfunction

	function automatic logic signed [GRAD_W-1:0] apply_sign(
		input logic signed [1:0]        g,
		input logic signed [GRAD_W-1:0] v
	);
		logic signed [GRAD_W-1:0] r;
		if (g > 0)
			r = v;
		else if (g < 0)
			r = -v;
		else
			r = '0;
		return r;
	endfunction

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [PROD_W-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > SAT_HI)
			r = SAT_HI[OUT_W-1:0];
		else if (v < SAT_LO)
			r = SAT_LO[OUT_W-1:0];
		else
			r = v[OUT_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

### hdl/tsf_if.sv
// ----------------------------------------------------------------------------
// tsf_if
// Valid/ready channels of the evaluator: reference point in, node result
// out, and the element order write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsf_pt_if;
	logic                             valid;
	logic                             ready;
	logic signed [tsf_pkg::IN_W-1:0]  xi_coord;
	logic signed [tsf_pkg::IN_W-1:0]  eta_coord;
	logic signed [tsf_pkg::IN_W-1:0]  zeta_coord;

	modport source (output valid, xi_coord, eta_coord, zeta_coord, input ready);
	modport sink   (input valid, xi_coord, eta_coord, zeta_coord, output ready);
endinterface

interface tsf_node_if;
	logic                             valid;
	logic                             ready;
	logic [tsf_pkg::IDX_W-1:0]        node_index;
	logic signed [tsf_pkg::OUT_W-1:0] shape_value;
	logic signed [tsf_pkg::OUT_W-1:0] grad_xi;
	logic signed [tsf_pkg::OUT_W-1:0] grad_eta;
	logic signed [tsf_pkg::OUT_W-1:0] grad_zeta;
	logic                             last_node;

	modport source (output valid, node_index, shape_value, grad_xi, grad_eta, grad_zeta,
		last_node, input ready);
	modport sink   (input valid, node_index, shape_value, grad_xi, grad_eta, grad_zeta,
		last_node, output ready);
endinterface

interface tsf_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [tsf_pkg::ORD_W-1:0] element_order;

	modport source (output valid, element_order, input ready);
	modport sink   (input valid, element_order, output ready);
endinterface

`default_nettype wire

### hdl/tsf_cfg_reg.sv
// ----------------------------------------------------------------------------
// tsf_cfg_reg
// Element order register, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tsf_cfg_reg (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tsf_cfg_if.sink    cfg,
	output logic       linear
);

	logic [tsf_pkg::ORD_W-1:0] order_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= tsf_pkg::ORDER_QUAD;
		end else if (cfg.valid) begin
			order_q <= cfg.element_order;
		end
	end

	// any code other than linear means quadratic
	assign linear = (order_q == tsf_pkg::ORDER_LINEAR);

endmodule

`default_nettype wire

### hdl/tsf_node_calc.sv
// ----------------------------------------------------------------------------
// tsf_node_calc
// Evaluates one node: shape value and its three reference derivatives
// from the barycentric coordinates, saturated; quadratic values are rounded.
// ----------------------------------------------------------------------------
`default_nettype none

module tsf_node_calc (
	input  tsf_pkg::lam_t             lam [4],
	input  wire logic [tsf_pkg::IDX_W-1:0] k,
	input  wire logic                 linear,
	output tsf_pkg::node_res_t        res
);

	logic [1:0]                         a;
	logic [1:0]                         b;
	logic                               corner;
	tsf_pkg::lam_t                      la;
	tsf_pkg::lam_t                      lb;
	logic signed [tsf_pkg::MUL_A_W-1:0] m1;
	logic signed [tsf_pkg::PROD_W-1:0]  prod;
	logic signed [tsf_pkg::PROD_W:0]    rnd;
	logic signed [tsf_pkg::PROD_W:0]    rnd_sh;
	logic signed [tsf_pkg::PROD_W-1:0]  val;
	logic signed [tsf_pkg::GRAD_W-1:0]  grad [3];
	logic signed [tsf_pkg::GRAD_W-1:0]  one_w;
	logic signed [tsf_pkg::GRAD_W-1:0]  la_w;
	logic signed [tsf_pkg::GRAD_W-1:0]  lb_w;

	assign a      = tsf_pkg::node_a(k);
	assign b      = tsf_pkg::node_b(k);
	assign corner = (a == b);
	assign la     = lam[a];
	assign lb     = lam[b];
	assign one_w  = tsf_pkg::GRAD_W'(tsf_pkg::ONE);
	assign la_w   = tsf_pkg::GRAD_W'(la);
	assign lb_w   = tsf_pkg::GRAD_W'(lb);

	// corner: (2L - 1) * L, edge: 4La * Lb
	always_comb begin
		if (corner)
			m1 = (tsf_pkg::MUL_A_W'(la) <<< 1) - tsf_pkg::MUL_A_W'(tsf_pkg::ONE);
		else
			m1 = tsf_pkg::MUL_A_W'(la) <<< 2;
	end

	assign prod   = tsf_pkg::PROD_W'(m1) * tsf_pkg::PROD_W'(lb);
	assign rnd    = tsf_pkg::HALF + (tsf_pkg::PROD_W + 1)'(prod);
	assign rnd_sh = rnd >>> tsf_pkg::FRAC_BITS;

	always_comb begin
		if (linear)
			val = tsf_pkg::PROD_W'(la);
		else
			val = rnd_sh[tsf_pkg::PROD_W-1:0];
	end

	always_comb begin
		for (int d = 0; d < 3; d++) begin
			if (linear)
				grad[d] = tsf_pkg::apply_sign(tsf_pkg::lam_grad(a, d), one_w);
			else if (corner)
				grad[d] = tsf_pkg::apply_sign(tsf_pkg::lam_grad(a, d),
					(la_w <<< 2) - one_w);
			else
				grad[d] = (tsf_pkg::apply_sign(tsf_pkg::lam_grad(a, d), lb_w)
					+ tsf_pkg::apply_sign(tsf_pkg::lam_grad(b, d), la_w)) <<< 2;
		end
	end

	always_comb begin
		res.node_index  = k;
		res.shape_value = tsf_pkg::sat_out(val);
		res.grad_xi     = tsf_pkg::sat_out(tsf_pkg::PROD_W'(grad[0]));
		res.grad_eta    = tsf_pkg::sat_out(tsf_pkg::PROD_W'(grad[1]));
		res.grad_zeta   = tsf_pkg::sat_out(tsf_pkg::PROD_W'(grad[2]));
		res.last_node   = linear ? (k == tsf_pkg::LAST_LINEAR) : (k == tsf_pkg::LAST_QUAD);
	end

endmodule

`default_nettype wire

### hdl/tet_shape_function_eval.sv
// ----------------------------------------------------------------------------
// tet_shape_function_eval
// Four- and ten-node tetrahedron shape functions and derivatives at one
// reference point, one node result per item on the output channel.
// ----------------------------------------------------------------------------
// A point item is registered with its barycentric coordinates and then
// produces one node result per cycle while the output side is ready, 4
// results per point in linear order and 10 in quadratic order, as the
// single node evaluator (one multiplier) walks the nodes. The next point
// is taken in the cycle its predecessor's last node is loaded into the
// output register, so points stream with no gap while the output side is
// ready. Results sit in that output register, so a stalled consumer only
// holds the walk. The element order register resets to quadratic and is
// meant to be written between points.
`default_nettype none

module tet_shape_function_eval (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tsf_pt_if.sink      point,
	tsf_node_if.source  node,
	tsf_cfg_if.sink     cfg
);

	logic                       linear;
	logic                       pt_vld_s1;
	tsf_pkg::lam_t              lam_s1 [4];
	logic [tsf_pkg::IDX_W-1:0]  k_s1;
	tsf_pkg::node_res_t         res;
	tsf_pkg::node_res_t         res_q;
	logic                       out_vld_q;
	logic                       adv;
	logic                       accept;
	tsf_pkg::lam_t              lx;
	tsf_pkg::lam_t              ly;
	tsf_pkg::lam_t              lz;

	tsf_cfg_reg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.linear (linear)
	);

	tsf_node_calc u_calc (
		.lam    (lam_s1),
		.k      (k_s1),
		.linear (linear),
		.res    (res)
	);

	assign adv         = pt_vld_s1 && (!out_vld_q || node.ready);
	assign point.ready = !pt_vld_s1 || (adv && res.last_node);
	assign accept      = point.valid && point.ready;

	assign lx = tsf_pkg::LAM_W'(point.xi_coord);
	assign ly = tsf_pkg::LAM_W'(point.eta_coord);
	assign lz = tsf_pkg::LAM_W'(point.zeta_coord);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_vld_s1 <= 1'b0;
			k_s1      <= '0;
		end else if (accept) begin
			// a new point may load in the cycle the last node leaves
			pt_vld_s1 <= 1'b1;
			k_s1      <= '0;
		end else if (adv) begin
			k_s1 <= k_s1 + tsf_pkg::IDX_W'(1);
			if (res.last_node)
				pt_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lam_s1[0] <= tsf_pkg::ONE - lx - ly - lz;
			lam_s1[1] <= lx;
			lam_s1[2] <= ly;
			lam_s1[3] <= lz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (node.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res;
	end

	assign node.valid       = out_vld_q;
	assign node.node_index  = res_q.node_index;
	assign node.shape_value = res_q.shape_value;
	assign node.grad_xi     = res_q.grad_xi;
	assign node.grad_eta    = res_q.grad_eta;
	assign node.grad_zeta   = res_q.grad_zeta;
	assign node.last_node   = res_q.last_node;

endmodule

`default_nettype wire

### hdl/tsf_checker.sv
// ----------------------------------------------------------------------------
// tsf_checker
// Port-level checks of the evaluator's node result stream, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tsf_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic [tsf_pkg::IDX_W-1:0] out_index,
	input wire logic                      out_last
);

	// a result waiting on the consumer stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("node result dropped while stalled");

	// nodes of one point go out back to back in order
	a_node_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=>
			out_valid && (out_index == $past(out_index) + tsf_pkg::IDX_W'(1)))
		else $error("node sequence broken");

	// the last node is the final corner or the final edge
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |->
			(out_index == tsf_pkg::LAST_LINEAR) || (out_index == tsf_pkg::LAST_QUAD))
		else $error("last flag on wrong node");

	// a node index past the last edge never shows
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_index <= tsf_pkg::LAST_QUAD)
		else $error("node index out of range");

endmodule

bind tet_shape_function_eval tsf_checker u_tsf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (node.valid),
	.out_ready (node.ready),
	.out_index (node.node_index),
	.out_last  (node.last_node)
);

`default_nettype wire
